[rtl/nmh_pkg.sv]
// ----------------------------------------------------------------------------
// nmh_pkg : shared types and constants of the nearest midpoint histogram
// Item words, reference entry layout, opcodes and sequencer states.
// ----------------------------------------------------------------------------
package nmh_pkg;

    // Default sizes
    localparam int DIST_BINS_DEF   = 1024;
    localparam int LENGTH_BINS_DEF = 512;
    localparam int REF_DEPTH_DEF   = 4096;

    // Opcodes of the input word
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    // Kinds of the result word
    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_BIN  = 1'b1;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  chrom;
        logic [31:0] midpoint;
        logic [31:0] pos_start;
        logic [31:0] pos_end;
        logic [9:0]  bin_dist;
        logic [8:0]  bin_length;
    } in_word_t;

    typedef struct packed {
        logic        kind;
        logic        found;
        logic [31:0] distance;
        logic [31:0] read_length;
        logic        binned;
        logic [31:0] bin_count;
    } out_word_t;

    typedef struct packed {
        logic [7:0]  chrom;
        logic [31:0] mid;
    } ref_entry_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LEN,
        ST_PRIME,
        ST_SKIPCHK,
        ST_COND,
        ST_FETCH,
        ST_DL,
        ST_DH,
        ST_PICK,
        ST_ADDR,
        ST_HRD,
        ST_HWR,
        ST_OUT
    } state_t;

endpackage

[rtl/nmh_ram.sv]
// ----------------------------------------------------------------------------
// nmh_ram : generic single write port, single read port RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module nmh_ram #(
    parameter int              WIDTH = 32,
    parameter longint unsigned DEPTH = 1024
) (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic [WIDTH-1:0]           wdata,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/nearest_midpoint_histogram.sv]
// Load word: written in the idle state. Query word: ST_ADDR, ST_HRD, ST_HWR, then ST_OUT.
// Read word: length, cursor steps, both distances, pick, bin update; each cursor step is one
// reference RAM fetch plus one pass through the shared subtract/compare unit.
// One word in flight at a time; s_ready is high only between words.
// Reset (synchronous, aresetn low) clears all control state, then a clearing
// pass writes zero to every histogram bin.
// ----------------------------------------------------------------------------
// nearest_midpoint_histogram : nearest reference midpoint and 2D histogram
// Walks a sorted reference list with a cursor, finds the nearest midpoint of
// the read's sequence, counts (distance, length) in saturating bins and answers bin queries.
// ----------------------------------------------------------------------------
module nearest_midpoint_histogram import nmh_pkg::*; #(
    parameter int DIST_BINS   = DIST_BINS_DEF,
    parameter int LENGTH_BINS = LENGTH_BINS_DEF,
    parameter int REF_DEPTH   = REF_DEPTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_word,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_word
);

    localparam longint unsigned HIST_DEPTH = longint'(DIST_BINS) * longint'(LENGTH_BINS);
    localparam int HIST_AW = $clog2(HIST_DEPTH);
    localparam int DW      = $clog2(DIST_BINS);
    localparam int LW      = $clog2(LENGTH_BINS);
    localparam int RAW     = $clog2(REF_DEPTH);
    localparam int CW      = $clog2(REF_DEPTH + 1);

    state_t              state_reg, state_next;
    logic [HIST_AW-1:0]  clear_cnt_reg, clear_cnt_next;
    logic [CW-1:0]       ref_count_reg, ref_count_next;
    logic [CW-1:0]       cursor_reg, cursor_next;
    logic                primed_reg, primed_next;
    logic [7:0]          low_chrom_reg, low_chrom_next;
    logic [31:0]         low_mid_reg, low_mid_next;
    logic [7:0]          high_chrom_reg, high_chrom_next;
    logic [31:0]         high_mid_reg, high_mid_next;
    logic                out_valid_reg, out_valid_next;
    out_word_t           out_reg, out_next;
    in_word_t            item_reg, item_next;
    out_word_t           res_reg, res_next;
    logic [31:0]         dl_reg, dl_next;
    logic [31:0]         dh_reg, dh_next;
    logic [HIST_AW-1:0]  hist_addr_reg, hist_addr_next;

    // Shared subtract/compare unit
    logic [31:0] unit_a, unit_b, unit_abs;
    logic [32:0] unit_diff;
    logic        unit_lt;

    // RAM ports
    logic               ref_we;
    logic [RAW-1:0]     ref_raddr;
    ref_entry_t         ref_wdata, ref_rdata;
    logic               hist_we;
    logic [HIST_AW-1:0] hist_waddr;
    logic [31:0]        hist_wdata, hist_rdata;

    // Misc decode
    logic        is_query, adv, fl, fh;
    logic [31:0] addr_d, addr_l;

    assign unit_diff = {1'b0, unit_a} - {1'b0, unit_b};
    assign unit_lt   = unit_diff[32];
    assign unit_abs  = unit_lt ? (unit_b - unit_a) : unit_diff[31:0];

    assign is_query = (item_reg.op == OP_QUERY);
    assign addr_d   = is_query ? {22'd0, item_reg.bin_dist} : res_reg.distance;
    assign addr_l   = is_query ? {23'd0, item_reg.bin_length} : res_reg.read_length;
    assign fl       = (item_reg.chrom == low_chrom_reg);
    assign fh       = (item_reg.chrom == high_chrom_reg);
    assign adv      = (unit_lt && (item_reg.chrom >= high_chrom_reg))
                      || (item_reg.chrom > low_chrom_reg);

    assign ref_wdata = '{chrom: s_word.chrom, mid: s_word.midpoint};
    assign ref_raddr = (state_reg == ST_COND) ? cursor_reg[RAW-1:0] : '0;
    assign ref_we    = s_valid && s_ready && (s_word.op == OP_LOAD)
                       && (ref_count_reg != CW'(REF_DEPTH));

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;
    assign m_word  = out_reg;

    nmh_ram #(
        .WIDTH ($bits(ref_entry_t)),
        .DEPTH (longint'(REF_DEPTH))
    ) u_ref_ram (
        .aclk  (aclk),
        .we    (ref_we),
        .waddr (ref_count_reg[RAW-1:0]),
        .wdata (ref_wdata),
        .raddr (ref_raddr),
        .rdata (ref_rdata)
    );

    nmh_ram #(
        .WIDTH (32),
        .DEPTH (HIST_DEPTH)
    ) u_hist_ram (
        .aclk  (aclk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (hist_addr_reg),
        .rdata (hist_rdata)
    );

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clear_cnt_reg  <= '0;
            ref_count_reg  <= '0;
            cursor_reg     <= '0;
            primed_reg     <= 1'b0;
            low_chrom_reg  <= '0;
            low_mid_reg    <= '0;
            high_chrom_reg <= '0;
            high_mid_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clear_cnt_reg  <= clear_cnt_next;
            ref_count_reg  <= ref_count_next;
            cursor_reg     <= cursor_next;
            primed_reg     <= primed_next;
            low_chrom_reg  <= low_chrom_next;
            low_mid_reg    <= low_mid_next;
            high_chrom_reg <= high_chrom_next;
            high_mid_reg   <= high_mid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        out_reg       <= out_next;
        item_reg      <= item_next;
        res_reg       <= res_next;
        dl_reg        <= dl_next;
        dh_reg        <= dh_next;
        hist_addr_reg <= hist_addr_next;
    end

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        clear_cnt_next  = clear_cnt_reg;
        ref_count_next  = ref_count_reg;
        cursor_next     = cursor_reg;
        primed_next     = primed_reg;
        low_chrom_next  = low_chrom_reg;
        low_mid_next    = low_mid_reg;
        high_chrom_next = high_chrom_reg;
        high_mid_next   = high_mid_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        item_next       = item_reg;
        res_next        = res_reg;
        dl_next         = dl_reg;
        dh_next         = dh_reg;
        hist_addr_next  = hist_addr_reg;
        unit_a          = '0;
        unit_b          = '0;
        hist_we         = 1'b0;
        hist_waddr      = hist_addr_reg;
        hist_wdata      = '0;

        // Drop the result word once taken
        if (m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                hist_we        = 1'b1;
                hist_waddr     = clear_cnt_reg;
                clear_cnt_next = clear_cnt_reg + 1'b1;
                if (clear_cnt_reg == HIST_AW'(HIST_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    item_next = s_word;
                    res_next  = '0;
                    unique case (s_word.op)
                        OP_LOAD: begin
                            if (ref_we) begin
                                ref_count_next = ref_count_reg + 1'b1;
                            end
                        end
                        OP_READ: begin
                            res_next.kind = KIND_READ;
                            state_next    = ST_LEN;
                        end
                        OP_QUERY: begin
                            res_next.kind = KIND_BIN;
                            state_next    = ST_ADDR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LEN: begin
                unit_a               = item_reg.pos_start;
                unit_b               = item_reg.pos_end;
                res_next.read_length = unit_abs;
                priority if (primed_reg) begin
                    state_next = ST_SKIPCHK;
                end else if (ref_count_reg == '0) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_PRIME;
                end
            end
            ST_PRIME: begin
                low_chrom_next  = ref_rdata.chrom;
                low_mid_next    = ref_rdata.mid;
                high_chrom_next = ref_rdata.chrom;
                high_mid_next   = ref_rdata.mid;
                cursor_next     = CW'(1);
                primed_next     = 1'b1;
                state_next      = ST_SKIPCHK;
            end
            ST_SKIPCHK: begin
                if (item_reg.chrom < low_chrom_reg) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_COND;
                end
            end
            ST_COND: begin
                // Advance the bracket on adv; fetch the next entry unless the list ran out
                unit_a = high_mid_reg;
                unit_b = item_reg.midpoint;
                if (adv) begin
                    low_chrom_next = high_chrom_reg;
                    low_mid_next   = high_mid_reg;
                    if (cursor_reg >= ref_count_reg) begin
                        state_next = ST_DL;
                    end else begin
                        state_next = ST_FETCH;
                    end
                end else begin
                    state_next = ST_DL;
                end
            end
            ST_FETCH: begin
                high_chrom_next = ref_rdata.chrom;
                high_mid_next   = ref_rdata.mid;
                cursor_next     = cursor_reg + 1'b1;
                state_next      = ST_COND;
            end
            ST_DL: begin
                unit_a     = item_reg.midpoint;
                unit_b     = low_mid_reg;
                dl_next    = unit_abs;
                state_next = ST_DH;
            end
            ST_DH: begin
                unit_a     = item_reg.midpoint;
                unit_b     = high_mid_reg;
                dh_next    = unit_abs;
                state_next = ST_PICK;
            end
            ST_PICK: begin
                // Pick the nearer same-sequence end; a tie keeps the low end
                unit_a = dh_reg;
                unit_b = dl_reg;
                if (fl || fh) begin
                    res_next.found    = 1'b1;
                    res_next.distance = (fl && !(fh && unit_lt)) ? dl_reg : dh_reg;
                    state_next        = ST_ADDR;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_ADDR: begin
                hist_addr_next = HIST_AW'(addr_d[DW-1:0]) * HIST_AW'(LENGTH_BINS)
                                 + HIST_AW'(addr_l[LW-1:0]);
                if ((addr_d < 32'(DIST_BINS)) && (addr_l < 32'(LENGTH_BINS))) begin
                    state_next = ST_HRD;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_HRD: begin
                state_next = ST_HWR;
            end
            ST_HWR: begin
                // Return the bin, or bump it with saturation
                if (is_query) begin
                    res_next.bin_count = hist_rdata;
                end else begin
                    hist_we         = 1'b1;
                    hist_wdata      = (hist_rdata == '1) ? hist_rdata : hist_rdata + 1'b1;
                    res_next.binned = 1'b1;
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!out_valid_reg || m_ready) begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Checks
    a_load_count: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_word.op == OP_LOAD) && (ref_count_reg != CW'(REF_DEPTH))
        |=> ref_count_reg == $past(ref_count_reg) + 1'b1)
        else $error("reference count did not advance on load");

    a_cursor_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cursor_reg <= ref_count_reg)
        else $error("cursor ran past the loaded list");

    a_not_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_word.kind == KIND_READ) && !m_word.found
        |-> (m_word.distance == '0) && !m_word.binned && (m_word.bin_count == '0))
        else $error("read result without a match carries a distance or a count");

    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_ready && !hist_we == 1'b0)
        else $error("word accepted or bin left unwritten during clearing pass");

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench : self-checking bench of nearest_midpoint_histogram
// Loads a mostly sorted reference list, streams mostly sorted reads and bin
// queries through the valid/ready channels, and checks each result word
// against a predictor of the bracket walk and the saturating 2D histogram.
// ----------------------------------------------------------------------------
module testbench;
    import nmh_pkg::*;

    localparam int DIST_BINS   = DIST_BINS_DEF;
    localparam int LENGTH_BINS = LENGTH_BINS_DEF;
    localparam int REF_DEPTH   = REF_DEPTH_DEF;
    localparam int RAND_ITEMS  = 900;

    // Opcode that the block drops without a result
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        in_word_t  w;
        bit        typed;
        out_word_t res;
    } stim_row_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_word;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_word;

    // Predicted block state
    ref_entry_t  ref_list [REF_DEPTH];
    int unsigned ref_total;
    int unsigned next_ref;
    bit          bracket_ready;
    ref_entry_t  lo_ref;
    ref_entry_t  hi_ref;
    int unsigned bin_counts [int unsigned];
    int unsigned hit_bins [$];

    out_word_t   reports_due [$];
    out_word_t   head;
    stim_row_t   stim_rows [$];
    int          errors;
    int          burst_left;
    int          rx_phase_left;
    int          rx_hold;
    bit          rx_calm;

    nearest_midpoint_histogram #(
        .DIST_BINS  (DIST_BINS),
        .LENGTH_BINS(LENGTH_BINS),
        .REF_DEPTH  (REF_DEPTH)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_word (s_word),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_word (m_word)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(40_000_000);
        $display("** nearest_midpoint_histogram: FAILED **");
        $finish;
    end

    function automatic logic [31:0] span(input logic [31:0] a, input logic [31:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    // Apply one word to the predicted state and work out its result, if it has one
    function automatic bit walk_bracket_and_bin(input in_word_t w, output out_word_t r);
        logic [31:0] len;
        logic [31:0] near_dist;
        logic [31:0] hi_dist;
        bit          hit;
        int unsigned key;
        r         = '0;
        near_dist = '0;
        hit       = 1'b0;
        case (w.op)
            OP_LOAD: begin
                if (ref_total < REF_DEPTH) begin
                    ref_list[ref_total] = '{chrom: w.chrom, mid: w.midpoint};
                    ref_total++;
                end
                return 1'b0;
            end
            OP_READ: begin
                r.kind = KIND_READ;
                len = span(w.pos_start, w.pos_end);
                r.read_length = len;
                // first read with a list seeds both bracket ends with entry zero
                if (!bracket_ready) begin
                    if (ref_total == 0)
                        return 1'b1;
                    lo_ref = ref_list[0];
                    hi_ref = ref_list[0];
                    next_ref = 1;
                    bracket_ready = 1'b1;
                end
                if (w.chrom < lo_ref.chrom)
                    return 1'b1;
                while ((hi_ref.mid < w.midpoint && w.chrom >= hi_ref.chrom)
                        || w.chrom > lo_ref.chrom) begin
                    lo_ref = hi_ref;
                    if (next_ref >= ref_total)
                        break;
                    hi_ref = ref_list[next_ref];
                    next_ref++;
                end
                if (w.chrom == lo_ref.chrom) begin
                    near_dist = span(w.midpoint, lo_ref.mid);
                    hit = 1'b1;
                end
                if (w.chrom == hi_ref.chrom) begin
                    hi_dist = span(w.midpoint, hi_ref.mid);
                    if (!hit || hi_dist < near_dist)
                        near_dist = hi_dist;
                    hit = 1'b1;
                end
                if (!hit)
                    return 1'b1;
                r.found = 1'b1;
                r.distance = near_dist;
                if (near_dist < DIST_BINS && len < LENGTH_BINS) begin
                    key = near_dist * LENGTH_BINS + len;
                    if (!bin_counts.exists(key))
                        bin_counts[key] = 0;
                    if (bin_counts[key] != 32'hFFFF_FFFF)
                        bin_counts[key]++;
                    r.binned = 1'b1;
                    hit_bins.push_back(key);
                    if (hit_bins.size() > 64)
                        void'(hit_bins.pop_front());
                end
                return 1'b1;
            end
            OP_QUERY: begin
                r.kind = KIND_BIN;
                key = w.bin_dist * LENGTH_BINS + w.bin_length;
                if (w.bin_dist < DIST_BINS && w.bin_length < LENGTH_BINS
                        && bin_counts.exists(key))
                    r.bin_count = bin_counts[key];
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic in_word_t make_word(input logic [1:0] op, input logic [7:0] chrom,
                                           input logic [31:0] mid, input logic [31:0] p1,
                                           input logic [31:0] p2, input logic [9:0] bd,
                                           input logic [8:0] bl);
        return '{op: op, chrom: chrom, midpoint: mid, pos_start: p1, pos_end: p2,
                 bin_dist: bd, bin_length: bl};
    endfunction

    // Random word: every field random, opcode given
    function automatic in_word_t rand_word(input logic [1:0] op);
        logic [127:0] raw;
        in_word_t     w;
        raw = {$urandom, $urandom, $urandom, $urandom};
        w = in_word_t'(raw[$bits(in_word_t)-1:0]);
        w.op = op;
        return w;
    endfunction

    function automatic out_word_t skipped_read(input logic [31:0] len);
        out_word_t r;
        r = '0;
        r.kind = KIND_READ;
        r.read_length = len;
        return r;
    endfunction

    function automatic out_word_t bin_reply(input logic [31:0] count);
        out_word_t r;
        r = '0;
        r.kind = KIND_BIN;
        r.bin_count = count;
        return r;
    endfunction

    task automatic add_row(input in_word_t w, input bit typed, input out_word_t res);
        stim_rows.push_back('{w: w, typed: typed, res: res});
    endtask

    // Send one word in bursts with random gaps; log its result on acceptance
    task automatic drive_word(input in_word_t w, input bit typed, input out_word_t res);
        out_word_t predicted;
        bit        has_result;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_word  <= w;
        do @(posedge aclk); while (!s_ready);
        has_result = walk_bracket_and_bin(w, predicted);
        if (has_result)
            reports_due.push_back(typed ? res : predicted);
    endtask

    // Hold the sender until every pending result word has come out
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (reports_due.size() != 0);
        burst_left = 1;
    endtask

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= 10)
            $display("%0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
            flag_error($sformatf("%s mismatch: expected %h, got %h", name, want, got));
    endtask

    // Receiver: calm stretches alternate with choppy ones
    always @(posedge aclk) begin
        if (rx_phase_left == 0) begin
            rx_calm = ($urandom_range(0, 2) == 0);
            rx_phase_left = $urandom_range(50, 400);
        end
        rx_phase_left--;
        if (rx_calm) begin
            m_ready <= 1'b1;
        end else if (rx_hold > 0) begin
            rx_hold--;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 2) == 0) begin
            rx_hold = $urandom_range(0, 7);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Compare each accepted result word with the oldest one due
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (reports_due.size() == 0) begin
                flag_error($sformatf("result word with none due: %h", m_word));
            end else begin
                head = reports_due.pop_front();
                check_field("kind", head.kind, m_word.kind);
                check_field("found", head.found, m_word.found);
                check_field("distance", head.distance, m_word.distance);
                check_field("read_length", head.read_length, m_word.read_length);
                check_field("binned", head.binned, m_word.binned);
                check_field("bin_count", head.bin_count, m_word.bin_count);
            end
        end
    end

    initial begin
        in_word_t    w;
        int          words_sent;
        int          gen_chrom;
        int          target;
        int          n_reads;
        int unsigned key;
        logic [31:0] cur_mid;
        logic [31:0] seg_lo;
        logic [31:0] rm;
        logic [31:0] step;
        logic [31:0] len;
        bit          half_done;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_word = '0;
        burst_left = 0;
        ref_total = 0;
        next_ref = 0;
        bracket_ready = 1'b0;
        lo_ref = '0;
        hi_ref = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed words: empty histogram, empty list, brackets, ties, bin edges
        add_row(make_word(OP_QUERY, 0, 0, 0, 0, 0, 0), 1'b1, bin_reply(0));
        add_row(make_word(OP_QUERY, 0, 0, 0, 0, 10'd1023, 9'd511), 1'b1, bin_reply(0));
        add_row(make_word(OP_READ, 0, 100, 10, 30, 0, 0), 1'b1, skipped_read(20));
        add_row(make_word(OP_UNUSED, 8'hFF, '1, '1, '1, '1, '1), 1'b0, '0);
        add_row(make_word(OP_LOAD, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(make_word(OP_LOAD, 0, 1000, 0, 0, 0, 0), 1'b0, '0);
        add_row(make_word(OP_LOAD, 0, 1010, 0, 0, 0, 0), 1'b0, '0);
        add_row(make_word(OP_LOAD, 1, 5, 0, 0, 0, 0), 1'b0, '0);
        add_row(make_word(OP_READ, 0, 1005, 0, 32'hFFFF_FFFF, 0, 0), 1'b0, '0);
        add_row(make_word(OP_READ, 0, 1005, 100, 100, 0, 0), 1'b0, '0);
        add_row(make_word(OP_READ, 0, 1012, 300, 200, 0, 0), 1'b0, '0);
        add_row(make_word(OP_QUERY, 0, 0, 0, 0, 5, 0), 1'b0, '0);
        add_row(make_word(OP_QUERY, 0, 0, 0, 0, 2, 100), 1'b0, '0);
        add_row(make_word(OP_READ, 0, 0, 0, 383, 0, 0), 1'b0, '0);
        add_row(make_word(OP_READ, 0, 2033, 511, 0, 0, 0), 1'b0, '0);
        add_row(make_word(OP_QUERY, 0, 0, 0, 0, 10'd1023, 9'd511), 1'b0, '0);
        add_row(make_word(OP_QUERY, 0, 0, 0, 0, 768, 0), 1'b1, bin_reply(0));
        add_row(make_word(OP_READ, 1, '1, '1, 32'hFFFF_FFFE, 0, 0), 1'b0, '0);
        add_row(make_word(OP_LOAD, 1, '1, 0, 0, 0, 0), 1'b0, '0);
        add_row(make_word(OP_READ, 1, '1, 5, 5, 0, 0), 1'b0, '0);
        add_row(make_word(OP_READ, 0, 50, 60, 50, 0, 0), 1'b1, skipped_read(10));
        add_row(make_word(OP_QUERY, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        foreach (stim_rows[i])
            drive_word(stim_rows[i].w, stim_rows[i].typed, stim_rows[i].res);
        drain_results();

        // Random segments: mostly sorted loads, then reads with queries mixed in
        words_sent = 0;
        gen_chrom = 2;
        cur_mid = $urandom & 32'hFFFE_0000;
        half_done = 1'b0;
        while (words_sent < RAND_ITEMS) begin
            // step to a new sequence, paced to reach the top one near the end
            target = (255 * words_sent) / RAND_ITEMS;
            if (gen_chrom < 255 && (gen_chrom < target || $urandom_range(0, 3) == 0)) begin
                gen_chrom = (target > gen_chrom + 1) ? target : gen_chrom + 1;
                if (gen_chrom > 255)
                    gen_chrom = 255;
                cur_mid = $urandom & 32'hFFFE_0000;
            end
            seg_lo = cur_mid;

            repeat ($urandom_range(1, 8)) begin
                w = rand_word(OP_LOAD);
                w.chrom = 8'(gen_chrom);
                if ($urandom_range(0, 19) == 0) begin
                    w.midpoint = cur_mid - $urandom_range(0, 100);
                end else begin
                    cur_mid += $urandom_range(0, 40);
                    w.midpoint = cur_mid;
                end
                drive_word(w, 1'b0, '0);
                words_sent++;
            end

            n_reads = $urandom_range(1, 8);
            step = (cur_mid - seg_lo) / n_reads + 8;
            rm = (seg_lo > 50) ? seg_lo - $urandom_range(0, 50) : seg_lo;
            repeat (n_reads) begin
                w = rand_word(OP_READ);
                rm += ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3000)
                                                  : $urandom_range(0, step);
                w.chrom = 8'(gen_chrom);
                w.midpoint = rm;
                len = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 420);
                w.pos_end = w.pos_start + len;
                if ($urandom_range(0, 1) == 1)
                    {w.pos_start, w.pos_end} = {w.pos_end, w.pos_start};
                // a few out-of-order words: an older sequence or a wild position
                case ($urandom_range(0, 19))
                    0: w.chrom = 8'($urandom_range(0, gen_chrom - 1));
                    1: w.midpoint = $urandom;
                    default: ;
                endcase
                drive_word(w, 1'b0, '0);
                words_sent++;

                if ($urandom_range(0, 3) == 0) begin
                    w = rand_word(OP_QUERY);
                    if (hit_bins.size() > 0 && $urandom_range(0, 3) != 0) begin
                        key = hit_bins[$urandom_range(0, hit_bins.size() - 1)];
                        w.bin_dist = 10'(key / LENGTH_BINS);
                        w.bin_length = 9'(key % LENGTH_BINS);
                    end
                    drive_word(w, 1'b0, '0);
                    words_sent++;
                end
                if ($urandom_range(0, 29) == 0)
                    drive_word(rand_word(OP_UNUSED), 1'b0, '0);
            end

            if (!half_done && words_sent >= RAND_ITEMS / 2) begin
                half_done = 1'b1;
                drain_results();
            end
        end

        // Let the last words work through, then report
        s_valid <= 1'b0;
        while (reports_due.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (errors == 0)
            $display("** nearest_midpoint_histogram: PASSED **");
        else
            $display("** nearest_midpoint_histogram: FAILED **");
        $finish;
    end

endmodule
